>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CMB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/cmb_pkg.sv
// shared constants and types of the combination enumerator
// no dependencies
`timescale 1ns / 1ps

package cmb_pkg;

	localparam int MAX_SET    = 64;
	localparam int MAX_SUBSET = 16;

	localparam int N_W     = 7;                      // set_size register
	localparam int K_W     = 5;                      // subset_size register
	localparam int ELEM_W  = 6;                      // one stored index
	localparam int IDX_W   = $clog2(MAX_SUBSET);     // index row address
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W   = N_W;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 8;
	localparam int M_USER_W = 2;

	localparam logic [N_W-1:0] SET_SIZE_RST = N_W'(8);
	localparam logic [K_W-1:0] SUB_SIZE_RST = K_W'(3);

	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = CFG_IDX_W'(1);

	// access request to the index row memory
	typedef struct packed {
		logic              clear;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [ELEM_W-1:0] wr_data;
	} mem_req_t;

	// one result beat offered to the output register
	typedef struct packed {
		logic              vld;
		logic [ELEM_W-1:0] elem;
		logic              last;
		logic              exh;
		logic              empty;
	} beat_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EMIT = 4'b0010,
		ST_ADV  = 4'b0100,
		ST_SPEC = 4'b1000
	} seq_state_t;

endpackage

>>> hw/rtl/cmb_idx_mem.sv
// index row memory: one read and one write port, registered read data
// depends on cmb_pkg
`timescale 1ns / 1ps

module cmb_idx_mem (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmb_pkg::mem_req_t       req,
	output logic [cmb_pkg::ELEM_W-1:0] rd_data
);
	import cmb_pkg::*;

	logic [ELEM_W-1:0] mem_q [MAX_SUBSET];
	logic [MAX_SUBSET-1:0] valid_q;
	logic [ELEM_W-1:0] rdata_q;
	logic              rvld_q;
	logic [IDX_W-1:0]  raddr_q;

	// entry not written since the last rewind reads as its own position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_addr];
			rvld_q  <= valid_q[req.rd_addr];
			raddr_q <= req.rd_addr;
		end
	end

	assign rd_data = rvld_q ? rdata_q : ELEM_W'(raddr_q);

endmodule

>>> hw/rtl/cmb_seq.sv
// request sequencer: emits the index row, finds the pivot and refills
// depends on cmb_pkg
`timescale 1ns / 1ps

module cmb_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       restart,
	input  logic                       cfg_we,
	input  logic [cmb_pkg::N_W-1:0]    n_eff,
	input  logic [cmb_pkg::K_W-1:0]    k_eff,
	input  logic                       out_free,
	input  logic [cmb_pkg::ELEM_W-1:0] rd_data,
	output cmb_pkg::mem_req_t          mreq,
	output cmb_pkg::beat_t             beat
);
	import cmb_pkg::*;

	seq_state_t        state_q;
	logic              finished_q;
	logic [K_W-1:0]    rd_cnt_q;
	logic [K_W-1:0]    mv_cnt_q;
	logic              s1_vld_q;
	logic              found_q;
	logic [IDX_W-1:0]  wa_q;
	logic [ELEM_W-1:0] wv_q;
	logic              spec_exh_q;

	logic           accept;
	logic           move;
	logic           read_en;
	logic           last_mv;
	logic           wr_last;
	logic           below;
	logic           k_gt_n;
	logic           fin_eff;
	logic [N_W-1:0] limit;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign move      = (state_q == ST_EMIT) && s1_vld_q && out_free;
	assign read_en   = (state_q == ST_EMIT) && (rd_cnt_q < k_eff) && (!s1_vld_q || move);
	assign last_mv   = K_W'(mv_cnt_q + 1'b1) == k_eff;
	assign wr_last   = K_W'(K_W'(wa_q) + 1'b1) == k_eff;
	// largest value allowed at the position being emitted
	assign limit     = N_W'(n_eff - N_W'(k_eff) + N_W'(mv_cnt_q[IDX_W-1:0]));
	assign below     = N_W'(rd_data) < limit;
	assign k_gt_n    = N_W'(k_eff) > n_eff;
	assign fin_eff   = restart ? 1'b0 : finished_q;

	always_comb begin
		mreq.clear   = (accept && restart) || cfg_we;
		mreq.rd_en   = read_en;
		mreq.rd_addr = rd_cnt_q[IDX_W-1:0];
		mreq.wr_en   = (state_q == ST_ADV) && found_q;
		mreq.wr_addr = wa_q;
		mreq.wr_data = wv_q;
	end

	always_comb begin
		beat = '0;
		unique case (state_q)
			ST_SPEC: begin
				beat.vld   = 1'b1;
				beat.last  = 1'b1;
				beat.exh   = spec_exh_q;
				beat.empty = !spec_exh_q;
			end
			ST_EMIT: begin
				beat.vld  = s1_vld_q;
				beat.elem = rd_data;
				beat.last = last_mv;
			end
			default: beat = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			finished_q <= 1'b0;
			rd_cnt_q   <= '0;
			mv_cnt_q   <= '0;
			s1_vld_q   <= 1'b0;
			found_q    <= 1'b0;
			spec_exh_q <= 1'b0;
		end else begin
			if (read_en) begin
				rd_cnt_q <= K_W'(rd_cnt_q + 1'b1);
			end
			if (read_en) begin
				s1_vld_q <= 1'b1;
			end else if (move) begin
				s1_vld_q <= 1'b0;
			end
			if (move) begin
				mv_cnt_q <= K_W'(mv_cnt_q + 1'b1);
				if (below) begin
					found_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						finished_q <= 1'b0;
					end
					if (accept) begin
						rd_cnt_q <= '0;
						mv_cnt_q <= '0;
						found_q  <= 1'b0;
						if (fin_eff || k_gt_n) begin
							finished_q <= 1'b1;
							spec_exh_q <= 1'b1;
							state_q    <= ST_SPEC;
						end else if (k_eff == '0) begin
							finished_q <= 1'b1;
							spec_exh_q <= 1'b0;
							state_q    <= ST_SPEC;
						end else begin
							finished_q <= 1'b0;
							state_q    <= ST_EMIT;
						end
					end
				end
				ST_SPEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (move && last_mv) begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (!found_q) begin
						finished_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else if (wr_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pivot: rightmost position still below its limit, with its new value
	always_ff @(posedge clk) begin
		if (move && below) begin
			wa_q <= mv_cnt_q[IDX_W-1:0];
			wv_q <= ELEM_W'(rd_data + 1'b1);
		end else if (state_q == ST_ADV) begin
			wa_q <= IDX_W'(wa_q + 1'b1);
			wv_q <= ELEM_W'(wv_q + 1'b1);
		end
	end

endmodule

>>> hw/rtl/combination_enumerator.sv
// top level of the combination enumerator: config registers, output register
// depends on cmb_pkg, cmb_seq, cmb_idx_mem
`timescale 1ns / 1ps

// Steps through every k-subset of {0..n-1} in lexicographic order, starting
// from {0..k-1}. Each request beat on the slave side (tdata bit 0 = restart,
// which rewinds to the first combination first) yields the current
// combination as k result beats in ascending order, tlast on the final one,
// and then advances. Once every combination was given, or when k > n, each
// request yields one beat flagged exhausted (element 0); with k = 0 a single
// empty-combination beat is given, after which the block is exhausted.
// set_size (index 0) saturates at 64 and subset_size (index 1) at 16; a
// write to either rewinds the enumeration and must be made while idle.
// The index row lives in a 16-entry memory with one read and one write port.
// Sequence: a request is accepted, then the k indices are read one per
// cycle while the output register is free, with registered read data;
// then the refill writes the pivot and every index after it, one memory
// write per cycle, or writes nothing when no index can move; the pivot
// position and k set the refill length. Exhausted and empty requests give
// their single beat once the output register is free. The output
// register lets the next request be accepted while the final result
// beat still waits on m_tready.

module combination_enumerator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cmb_pkg::S_DATA_W-1:0]  s_tdata,   // [0] restart, rest zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cmb_pkg::M_DATA_W-1:0]  m_tdata,   // [5:0] element, rest zero
	output logic                          m_tlast,   // last_of_combination
	output logic [cmb_pkg::M_USER_W-1:0]  m_tuser,   // [0] exhausted, [1] empty_combination
	input  logic                          cfg_we,
	input  logic [cmb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cmb_pkg::CFG_W-1:0]     cfg_data
);
	import cmb_pkg::*;

	logic [N_W-1:0]    set_q;
	logic [K_W-1:0]    sub_q;
	logic [N_W-1:0]    n_eff;
	logic [K_W-1:0]    k_eff;

	logic              out_vld_q;
	logic [ELEM_W-1:0] elem_q;
	logic              last_q;
	logic              exh_q;
	logic              empty_q;
	logic              out_free;

	mem_req_t          mreq;
	beat_t             beat;
	logic [ELEM_W-1:0] rd_data;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= SET_SIZE_RST;
			sub_q <= SUB_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SET_SIZE:    set_q <= cfg_data;
				REG_SUBSET_SIZE: sub_q <= cfg_data[K_W-1:0];
				default:         set_q <= set_q;
			endcase
		end
	end

	// saturate to the sizes the index row supports
	assign n_eff = (set_q > N_W'(MAX_SET))    ? N_W'(MAX_SET)    : set_q;
	assign k_eff = (sub_q > K_W'(MAX_SUBSET)) ? K_W'(MAX_SUBSET) : sub_q;

	cmb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.restart   (s_tdata[0]),
		.cfg_we    (cfg_we),
		.n_eff     (n_eff),
		.k_eff     (k_eff),
		.out_free  (out_free),
		.rd_data   (rd_data),
		.mreq      (mreq),
		.beat      (beat)
	);

	cmb_idx_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd_data)
	);

	// output register, free when empty or being taken this cycle
	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (beat.vld && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat.vld && out_free) begin
			elem_q  <= beat.elem;
			last_q  <= beat.last;
			exh_q   <= beat.exh;
			empty_q <= beat.empty;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_DATA_W'(elem_q);
	assign m_tlast  = last_q;
	assign m_tuser  = {empty_q, exh_q};

endmodule

>>> hw/rtl/cmb_checker.sv
// port-level checker for the combination enumerator, bound to the top level
// depends on cmb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [cmb_pkg::S_DATA_W-1:0]  s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cmb_pkg::M_DATA_W-1:0]  m_tdata,
	input logic                          m_tlast,
	input logic [cmb_pkg::M_USER_W-1:0]  m_tuser,
	input logic                          cfg_we,
	input logic [cmb_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [cmb_pkg::CFG_W-1:0]     cfg_data
);
	import cmb_pkg::*;

	// a stalled result beat keeps its payload
	`CMB_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

	// an exhausted beat is alone, closes the request and carries element zero
	`CMB_ASSERT_IMP(a_exh_beat, clk, arst_n, m_tvalid && m_tuser[0], m_tlast && !m_tuser[1] && (m_tdata == '0))

	// an empty-combination beat closes the request
	`CMB_ASSERT_IMP(a_empty_beat, clk, arst_n, m_tvalid && m_tuser[1], m_tlast && (m_tdata == '0))

	// one request at a time: the slave side closes right after a request beat
	`CMB_ASSERT_NXT(a_one_req, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind combination_enumerator cmb_checker u_cmb_checker (.*);

>>> tb/sv/combination_enumerator_tb.sv
// self-checking testbench for the combination enumerator
// holds its own model of the subset walk and a scoreboard of result beats
// depends on cmb_pkg and combination_enumerator
`timescale 1ns / 1ps

module combination_enumerator_tb;

	import cmb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;  // many times the slowest legal run
	localparam int SETTLE      = 40;      // outlasts a refill at k = 16
	localparam int MAX_PRINTED = 40;

	// one expected result beat
	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic              last;
		logic              exh;
		logic              empty;
	} combo_beat_t;

	// model of the subset walk plus the queue of beats still to arrive
	class combo_predictor;
		logic [N_W-1:0] set_size_q;
		logic [K_W-1:0] subset_size_q;
		int unsigned    row[MAX_SUBSET];
		bit             done;
		combo_beat_t    pending[$];
		int unsigned    errors;

		function new();
			set_size_q    = SET_SIZE_RST;
			subset_size_q = SUB_SIZE_RST;
			errors        = 0;
			rewind();
		endfunction

		function void rewind();
			for (int i = 0; i < MAX_SUBSET; i++)
				row[i] = i;
			done = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == REG_SET_SIZE)
				set_size_q = value[N_W-1:0];
			else
				subset_size_q = value[K_W-1:0];
			rewind();
		endfunction

		function void push_beat(int unsigned element, bit last, bit exh, bit empty);
			combo_beat_t b;
			b.element = element[ELEM_W-1:0];
			b.last    = last;
			b.exh     = exh;
			b.empty   = empty;
			pending = {pending, b};
		endfunction

		// a request emits the current subset, then steps to the next one
		function void note_request(bit restart);
			int  n;
			int  k;
			bit  moved;
			n = (set_size_q > MAX_SET) ? MAX_SET : int'(set_size_q);
			k = (subset_size_q > MAX_SUBSET) ? MAX_SUBSET : int'(subset_size_q);
			if (restart)
				rewind();
			if (done || k > n) begin
				done = 1'b1;
				push_beat(0, 1'b1, 1'b1, 1'b0);
				return;
			end
			if (k == 0) begin
				done = 1'b1;
				push_beat(0, 1'b1, 1'b0, 1'b1);
				return;
			end
			for (int i = 0; i < k; i++)
				push_beat(row[i], i == k - 1, 1'b0, 1'b0);
			// rightmost index below its ceiling moves up, the tail follows it
			moved = 1'b0;
			for (int p = k - 1; p >= 0 && !moved; p--) begin
				if (row[p] < n - k + p) begin
					row[p]++;
					for (int m = p + 1; m < k; m++)
						row[m] = row[p] + (m - p);
					moved = 1'b1;
				end
			end
			if (!moved)
				done = 1'b1;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("ERROR at %0t ns: %s", $time, msg);
		endtask

		task check_beat(logic [ELEM_W-1:0] element, logic last, logic exh, logic empty);
			combo_beat_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat, element %0d", element));
				return;
			end
			want = pending.pop_front();
			if (element !== want.element)
				report($sformatf("element %0d, want %0d", element, want.element));
			if (last !== want.last)
				report($sformatf("tlast %b, want %b", last, want.last));
			if (exh !== want.exh)
				report($sformatf("exhausted %b, want %b", exh, want.exh));
			if (empty !== want.empty)
				report($sformatf("empty_combination %b, want %b", empty, want.empty));
		endtask
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic [M_USER_W-1:0]   m_tuser;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	int unsigned    cycle_count = 0;
	combo_predictor pred = new();

	combination_enumerator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [0] restart
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [5:0] element
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),   // [0] exhausted, [1] empty_combination
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("combination_enumerator: mismatch");
			$finish;
		end
	end

	// idle lengths: half none, most short, a few long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// sink side: bursts of ready broken by stalls of random length
	initial begin
		int unsigned burst;
		int unsigned stall;
		forever begin
			burst = $urandom_range(1, 40);
			stall = gap_len();
			m_tready <= 1'b1;
			repeat (burst) @(posedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// every accepted result beat goes against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pred.check_beat(m_tdata[ELEM_W-1:0], m_tlast, m_tuser[0], m_tuser[1]);
	end

	task automatic wait_drained();
		while (pred.pending.size() != 0)
			@(posedge clk);
	endtask

	// one request beat; keep leaves tvalid high for a back-to-back follower unless an idle gap is drawn
	task automatic send_request(input bit restart, input bit keep);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(restart);
		do
			@(posedge clk);
		while (!s_tready);
		pred.note_request(restart);
		gap = keep ? gap_len() : 0;
		if (!keep || gap != 0)
			s_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// registers change only once the block is drained and its refill is over
	task automatic configure(input logic [N_W-1:0] n, input logic [K_W-1:0] k);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_SET_SIZE;
		cfg_data <= n;
		@(posedge clk);
		pred.write_reg(REG_SET_SIZE, n);
		cfg_idx  <= REG_SUBSET_SIZE;
		cfg_data <= CFG_W'(k);
		@(posedge clk);
		pred.write_reg(REG_SUBSET_SIZE, CFG_W'(k));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned sent;
		int unsigned count;
		int unsigned sel;
		int unsigned n;
		int unsigned k;
		bit          pause;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings n = 8, k = 3, then a restart mid-walk
		send_request(1'b0, 1'b1);
		send_request(1'b0, 1'b1);
		send_request(1'b1, 1'b0);
		// k equal to n: one subset, then exhausted
		configure(7'd4, 5'd4);
		send_request(1'b0, 1'b1);
		send_request(1'b0, 1'b0);
		// k above n: exhausted at once
		configure(7'd3, 5'd5);
		send_request(1'b0, 1'b0);
		// empty subset, exhausted after it, restart brings it back
		configure(7'd5, 5'd0);
		send_request(1'b0, 1'b1);
		send_request(1'b0, 1'b1);
		send_request(1'b1, 1'b0);
		// zero-sized set
		configure(7'd0, 5'd0);
		send_request(1'b0, 1'b0);
		configure(7'd0, 5'd1);
		send_request(1'b0, 1'b0);
		// complete walk of all six 2-subsets of 4, then past the end
		configure(7'd4, 5'd2);
		for (int i = 0; i < 7; i++)
			send_request(1'b0, i != 6);
		// both registers above their ceilings
		configure(7'd127, 5'd31);
		send_request(1'b0, 1'b1);
		send_request(1'b1, 1'b0);
		// widest subset that fits exactly
		configure(7'd16, 5'd16);
		send_request(1'b0, 1'b1);
		send_request(1'b0, 1'b0);

		// long walk at the widest sizes: the last index climbs to 63
		configure($urandom_range(1) ? 7'd127 : 7'd64, 5'd16);
		for (int i = 0; i < 50; i++) begin
			send_request(1'b0, i != 20 && i != 49);
			if (i == 20)
				wait_drained();
		end
		sent = 50;

		// short walks, mostly over small sets; most of them run to the end
		while (sent < 100) begin
			sel = $urandom_range(9);
			n = $urandom_range(1, 7);
			if (sel == 0)
				k = 0;
			else if (sel == 1)
				k = $urandom_range(n + 1, 31);
			else if (sel == 2) begin
				n = $urandom_range(8, 127);
				k = $urandom_range(1, 16);
			end else
				k = $urandom_range(1, n);
			count = $urandom_range(4, 16);
			if (count > 100 - sent)
				count = 100 - sent;
			configure(N_W'(n), K_W'(k));
			for (int i = 0; i < count; i++) begin
				pause = ($urandom_range(19) == 0);
				send_request($urandom_range(7) == 0, i != count - 1 && !pause);
				if (pause)
					wait_drained();
			end
			sent += count;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (pred.errors == 0)
			$display("combination_enumerator: match");
		else
			$display("combination_enumerator: mismatch");
		$finish;
	end

endmodule
